[rtl/core/zscore_anomaly_detector_top_defines.svh]
// ----------------------------------------------------------------------------
// zscore_anomaly_detector_top_defines
// Assertion macros shared by the z-score detector checkers.
// ----------------------------------------------------------------------------
`ifndef ZSCORE_ANOMALY_DETECTOR_TOP_DEFINES_SVH
`define ZSCORE_ANOMALY_DETECTOR_TOP_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define ZAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked after a delay from the antecedent.
`define ZAD_ASSERT_LATER(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[rtl/core/zad_pkg.sv]
// ----------------------------------------------------------------------------
// zad_pkg
// Widths, constants and shared types of the z-score anomaly detector.
// ----------------------------------------------------------------------------
package zad_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned WINDOW_DEPTH = 128;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned MAG_W        = SAMPLE_BITS;
  localparam int unsigned SUM_W        = SAMPLE_BITS + SLOT_W + 1;
  localparam int unsigned SQ_W         = 2 * SAMPLE_BITS - 1 + SLOT_W;
  localparam int unsigned DEV_W        = SUM_W + 1;
  localparam int unsigned ADEV_W       = DEV_W - 1;
  localparam int unsigned SS_W         = 2 * (SUM_W - 1);
  localparam int unsigned THRESH_W     = 16;
  localparam int unsigned THRESH_FRAC  = 8;
  localparam int unsigned L_SHIFT      = 2 * THRESH_FRAC;
  localparam int unsigned L_W          = 2 * ADEV_W + L_SHIFT;
  localparam int unsigned NQ_W         = SQ_W + CNT_W;
  localparam int unsigned T2_W         = 2 * THRESH_W;
  localparam int unsigned R_W          = NQ_W + T2_W;
  localparam int unsigned MUL_W        = 32;
  localparam int unsigned PROD_W       = 2 * MUL_W;

  localparam logic [THRESH_W-1:0] THRESH_DEFAULT = THRESH_W'(768);
  localparam logic [CNT_W-1:0]    MIN_FILL       = CNT_W'(2);

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_op_t;

endpackage

[rtl/core/zad_sample_if.sv]
// ----------------------------------------------------------------------------
// zad_sample_if
// Valid/ready channel carrying one signed sample word.
// ----------------------------------------------------------------------------
interface zad_sample_if;
  import zad_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[rtl/core/zad_flag_if.sv]
// ----------------------------------------------------------------------------
// zad_flag_if
// Valid/ready channel carrying one anomaly flag word.
// ----------------------------------------------------------------------------
interface zad_flag_if;
  logic valid;
  logic ready;
  logic is_anomaly;

  modport source (output valid, output is_anomaly, input ready);
  modport sink   (input valid, input is_anomaly, output ready);
endinterface

[rtl/core/zad_mul.sv]
// ----------------------------------------------------------------------------
// zad_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module zad_mul (
  input  logic                         clk_i,
  input  zad_pkg::mul_op_t             op_i,
  output logic [zad_pkg::PROD_W-1:0]   prod_o
);
  import zad_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_i.a) * PROD_W'(op_i.b);
  end

  assign prod_o = prod_q;
endmodule

[rtl/core/zscore_anomaly_detector_top.sv]
// ----------------------------------------------------------------------------
// zscore_anomaly_detector_top
// Flow: after a sample is accepted the sequencer steps the single shared 32x32
//   multiplier through scoring and window update, then loads the flag word into
//   the output register; no new sample is accepted until that load is done.
// Reset: clears sums, fill count, write slot, sequencer and output valid;
//   threshold returns to 3.0. Window memory is not cleared.
// ----------------------------------------------------------------------------
module zscore_anomaly_detector_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  zad_sample_if.sink                      sample_i,
  zad_flag_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [zad_pkg::THRESH_W-1:0]    cfg_wdata_i
);
  import zad_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_NV   = 14'h0002,
    ST_DEV  = 14'h0004,
    ST_DD   = 14'h0008,
    ST_NQL  = 14'h0010,
    ST_NQH  = 14'h0020,
    ST_TT   = 14'h0040,
    ST_VAR  = 14'h0080,
    ST_TVL  = 14'h0100,
    ST_TVH  = 14'h0200,
    ST_CMP  = 14'h0400,
    ST_OO   = 14'h0800,
    ST_UPD  = 14'h1000,
    ST_OUT  = 14'h2000
  } state_e;

  state_e                        state_q, state_d;
  logic signed [SAMPLE_BITS-1:0] v_q, old_q;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic [SQ_W-1:0]               sqsum_q, sqsum_d;
  logic [CNT_W-1:0]              fill_q, fill_d;
  logic [SLOT_W-1:0]             slot_q, slot_d;
  logic [THRESH_W-1:0]           thr_q;
  logic signed [DEV_W-1:0]       dev_q, dev_d;
  logic [L_W-1:0]                l_q;
  logic [SS_W-1:0]               s2_q;
  logic [R_W-1:0]                acc_q, acc_hi;
  logic [T2_W-1:0]               t2_q;
  logic [NQ_W-1:0]               var_q;
  logic [2*MAG_W-1:0]            sqnew_q;
  logic                          flag_q;
  logic                          out_valid_q, out_valid_d, out_flag_q;

  logic [SAMPLE_BITS-1:0]        win_mem [WINDOW_DEPTH];

  logic                          accept, full, out_load;
  logic [MAG_W-1:0]              vmag, omag;
  logic [SUM_W-2:0]              smag;
  logic [ADEV_W-1:0]             adev;
  logic signed [DEV_W-1:0]       nv;
  logic [THRESH_W-1:0]           thr_eff;
  logic [PROD_W-1:0]             prod;
  mul_op_t                       mop;

  zad_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mop),
    .prod_o (prod)
  );

  assign accept   = sample_i.valid && sample_i.ready;
  assign full     = (fill_q == CNT_W'(WINDOW_DEPTH));
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || result_o.ready);
  assign vmag     = v_q[SAMPLE_BITS-1] ? MAG_W'(~v_q + 1'b1) : MAG_W'(v_q);
  assign omag     = old_q[SAMPLE_BITS-1] ? MAG_W'(~old_q + 1'b1) : MAG_W'(old_q);
  assign smag     = sum_q[SUM_W-1] ? (SUM_W-1)'(-sum_q) : (SUM_W-1)'(sum_q);
  assign adev     = dev_q[DEV_W-1] ? ADEV_W'(-dev_q) : ADEV_W'(dev_q);
  assign thr_eff  = (thr_q == '0) ? THRESH_DEFAULT : thr_q;
  assign nv       = DEV_W'(prod[CNT_W+MAG_W-1:0]);
  assign dev_d    = (v_q[SAMPLE_BITS-1] ? -nv : nv) - DEV_W'(sum_q);
  assign acc_hi   = acc_q + (R_W'(prod) << MUL_W);

  always_comb begin
    mop = '0;
    case (state_q)
      ST_NV:   begin mop.a = MUL_W'(fill_q);  mop.b = MUL_W'(vmag); end
      ST_DEV:  begin mop.a = MUL_W'(smag);    mop.b = MUL_W'(smag); end
      ST_DD:   begin mop.a = MUL_W'(adev);    mop.b = MUL_W'(adev); end
      ST_NQL:  begin mop.a = MUL_W'(fill_q);  mop.b = sqsum_q[MUL_W-1:0]; end
      ST_NQH:  begin mop.a = MUL_W'(fill_q);  mop.b = MUL_W'(sqsum_q[SQ_W-1:MUL_W]); end
      ST_TT:   begin mop.a = MUL_W'(thr_eff); mop.b = MUL_W'(thr_eff); end
      ST_TVL:  begin mop.a = MUL_W'(t2_q);    mop.b = var_q[MUL_W-1:0]; end
      ST_TVH:  begin mop.a = MUL_W'(t2_q);    mop.b = MUL_W'(var_q[NQ_W-1:MUL_W]); end
      ST_CMP:  begin mop.a = MUL_W'(vmag);    mop.b = MUL_W'(vmag); end
      ST_OO:   begin mop.a = MUL_W'(omag);    mop.b = MUL_W'(omag); end
      default: mop = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_NV;
      ST_NV:   state_d = ST_DEV;
      ST_DEV:  state_d = ST_DD;
      ST_DD:   state_d = ST_NQL;
      ST_NQL:  state_d = ST_NQH;
      ST_NQH:  state_d = ST_TT;
      ST_TT:   state_d = ST_VAR;
      ST_VAR:  state_d = ST_TVL;
      ST_TVL:  state_d = ST_TVH;
      ST_TVH:  state_d = ST_CMP;
      ST_CMP:  state_d = ST_OO;
      ST_OO:   state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sum_d   = sum_q;
    sqsum_d = sqsum_q;
    fill_d  = fill_q;
    slot_d  = slot_q;
    if (state_q == ST_UPD) begin
      sum_d   = sum_q + SUM_W'(v_q) - (full ? SUM_W'(old_q) : '0);
      sqsum_d = sqsum_q + SQ_W'(sqnew_q) - (full ? SQ_W'(prod[2*MAG_W-1:0]) : '0);
      fill_d  = full ? fill_q : fill_q + 1'b1;
      slot_d  = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !result_o.ready;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      sqsum_q     <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      thr_q       <= THRESH_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sqsum_q     <= sqsum_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) v_q <= sample_i.sample;
    if (state_q == ST_DEV) dev_q <= dev_d;
    if (state_q == ST_DD) s2_q <= prod[SS_W-1:0];
    if (state_q == ST_NQL) l_q <= {prod[2*ADEV_W-1:0], {L_SHIFT{1'b0}}};
    if (state_q == ST_NQH || state_q == ST_TVH) acc_q <= R_W'(prod);
    if (state_q == ST_TT) acc_q <= acc_hi;
    if (state_q == ST_VAR) begin
      t2_q  <= prod[T2_W-1:0];
      var_q <= (acc_q < R_W'(s2_q)) ? '0 : NQ_W'(acc_q - R_W'(s2_q));
    end
    if (state_q == ST_CMP) flag_q <= (fill_q >= MIN_FILL) && (R_W'(l_q) > acc_hi);
    if (state_q == ST_OO) sqnew_q <= prod[2*MAG_W-1:0];
    if (out_load) out_flag_q <= flag_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) win_mem[slot_q] <= v_q;
    if (accept) old_q <= win_mem[slot_q];
  end

  assign sample_i.ready      = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.is_anomaly = out_flag_q;
endmodule

[rtl/core/zad_check.sv]
// ----------------------------------------------------------------------------
// zad_check
// Port-level checks of the z-score detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "zscore_anomaly_detector_top_defines.svh"

module zad_check (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_flag_i
);
  `ZAD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready high right after accept")
  `ZAD_ASSERT_LATER(a_still_busy, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "ready high two cycles after accept")
  `ZAD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "stalled word dropped")
  `ZAD_ASSERT_NEXT(a_flag_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_flag_i), "stalled word changed")
endmodule

bind zscore_anomaly_detector_top zad_check u_zad_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_flag_i  (result_o.is_anomaly)
);
